// ===== hw/rtl/tcc_pkg.sv =====
// Shared types and constants for the text console cursor engine.
package tcc_pkg;

   // Operation codes carried in the request func field.
   typedef enum logic [1:0] {
      FUNC_PRINT  = 2'd0,
      FUNC_MOVE   = 2'd1,
      FUNC_COLORS = 2'd2,
      FUNC_FORE   = 2'd3
   } func_type;

   // Control register indexes on the csr port.
   typedef enum logic [1:0] {
      CSR_LAST_COLUMN  = 2'd0,
      CSR_LAST_ROW     = 2'd1,
      CSR_DISPLAY_PAGE = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // Characters handled by the cursor logic itself.
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_RETURN  = 8'd13;
   localparam logic [7:0] CHAR_TAB     = 8'd9;

   // Reset values and attribute fields.
   localparam logic [7:0] ATTR_RESET        = 8'h07;
   localparam logic [7:0] BG_MASK           = 8'h70;
   localparam logic [7:0] LAST_COLUMN_RESET = 8'd79;
   localparam logic [7:0] LAST_ROW_RESET    = 8'd24;
   localparam logic [2:0] PAGE_RESET        = 3'd0;

   // One result held in the output register.
   typedef struct packed {
      logic       write_valid;
      logic [7:0] write_char;
      logic [7:0] write_attr;
      logic [2:0] write_page;
      logic [7:0] write_row;
      logic [7:0] write_column;
      logic       scroll_lines;
      logic [7:0] cursor_row;
      logic [7:0] cursor_column;
   } rsp_type;

endpackage

// ===== hw/rtl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: cursor state, controls and result register.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | func, char_code, target_row/column, colors
//  rsp     | out       | rsp_valid / rsp_ready | cell write, scroll request, new cursor
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// Each request is finished in the cycle it is accepted; its result appears in the output
// register in the next cycle, and a new request can be taken every cycle unless rsp stalls.
// The output register is the only stage: req_ready is high while it is empty or being read.
// A stall on rsp holds the result and stops new requests; cursor and attribute do not move.
// Synchronous reset clears the cursor, sets attribute 0x07 and the limits to 79 by 24.
// Control writes are always taken (csr_ready is tied high).
module text_console_cursor_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_target_row,
   input  logic [7:0] req_target_column,
   input  logic [3:0] req_background,
   input  logic [3:0] req_foreground,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_write_valid,
   output logic [7:0] rsp_write_char,
   output logic [7:0] rsp_write_attr,
   output logic [2:0] rsp_write_page,
   output logic [7:0] rsp_write_row,
   output logic [7:0] rsp_write_column,
   output logic       rsp_scroll_lines,
   output logic [7:0] rsp_cursor_row,
   output logic [7:0] rsp_cursor_column,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   logic [7:0] last_column_ff, last_column_in;
   logic [7:0] last_row_ff, last_row_in;
   logic [2:0] page_ff, page_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] column_ff, column_in;
   logic [7:0] attr_ff, attr_in;
   logic       rsp_valid_ff, rsp_valid_in;
   tcc_pkg::rsp_type rsp_ff, rsp_in;

   logic       req_fire;
   logic [7:0] col_step;
   logic [7:0] row_step;
   logic [7:0] col_wrap;
   logic [7:0] row_wrap;
   logic       is_plain;
   tcc_pkg::func_type func;

   assign func      = tcc_pkg::func_type'(req_func);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Control register writes.
   always_comb begin
      last_column_in = last_column_ff;
      last_row_in    = last_row_ff;
      page_in        = page_ff;
      if (csr_valid) begin
         unique case (tcc_pkg::csr_index_type'(csr_index))
            tcc_pkg::CSR_LAST_COLUMN:  last_column_in = csr_data;
            tcc_pkg::CSR_LAST_ROW:     last_row_in    = csr_data;
            tcc_pkg::CSR_DISPLAY_PAGE: page_in        = csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Character handling: newline, return, tab or a plain cell write.
   always_comb begin
      col_step = column_ff;
      row_step = row_ff;
      is_plain = 1'b0;
      unique case (req_char_code)
         tcc_pkg::CHAR_NEWLINE: begin
            col_step = 8'd0;
            row_step = row_ff + 8'd1;
         end
         tcc_pkg::CHAR_RETURN: begin
            row_step = row_ff + 8'd1;
         end
         tcc_pkg::CHAR_TAB: begin
            col_step = {column_ff[7:3] + 5'd1, 3'b000};
         end
         default: begin
            is_plain = 1'b1;
            col_step = column_ff + 8'd1;
         end
      endcase
   end

   // Column wrap to the next row; the row clamp follows in the result logic.
   always_comb begin
      col_wrap = col_step;
      row_wrap = row_step;
      if (col_step > last_column_ff) begin
         col_wrap = 8'd0;
         row_wrap = row_step + 8'd1;
      end
   end

   // Next cursor, attribute and the result for the accepted request.
   always_comb begin
      row_in    = row_ff;
      column_in = column_ff;
      attr_in   = attr_ff;
      rsp_in    = '0;
      unique case (func)
         tcc_pkg::FUNC_PRINT: begin
            column_in = col_wrap;
            row_in    = row_wrap;
            if (row_wrap > last_row_ff) begin
               row_in              = last_row_ff;
               rsp_in.scroll_lines = 1'b1;
            end
            if (is_plain) begin
               rsp_in.write_valid  = 1'b1;
               rsp_in.write_char   = req_char_code;
               rsp_in.write_row    = row_ff;
               rsp_in.write_column = column_ff;
            end
         end
         tcc_pkg::FUNC_MOVE: begin
            if (req_target_row <= last_row_ff && req_target_column <= last_column_ff) begin
               row_in    = req_target_row;
               column_in = req_target_column;
            end
         end
         tcc_pkg::FUNC_COLORS: begin
            attr_in = {1'b0, req_background[2:0], req_foreground};
         end
         tcc_pkg::FUNC_FORE: begin
            attr_in = (attr_ff & tcc_pkg::BG_MASK) | {4'd0, req_foreground};
         end
         default: ;
      endcase
      rsp_in.write_attr    = attr_in;
      rsp_in.write_page    = page_ff;
      rsp_in.cursor_row    = row_in;
      rsp_in.cursor_column = column_in;
   end

   // Output register occupancy.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and cursor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_column_ff <= tcc_pkg::LAST_COLUMN_RESET;
         last_row_ff    <= tcc_pkg::LAST_ROW_RESET;
         page_ff        <= tcc_pkg::PAGE_RESET;
         row_ff         <= 8'd0;
         column_ff      <= 8'd0;
         attr_ff        <= tcc_pkg::ATTR_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         last_column_ff <= last_column_in;
         last_row_ff    <= last_row_in;
         page_ff        <= page_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (req_fire) begin
            row_ff    <= row_in;
            column_ff <= column_in;
            attr_ff   <= attr_in;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_ff.write_valid;
   assign rsp_write_char    = rsp_ff.write_char;
   assign rsp_write_attr    = rsp_ff.write_attr;
   assign rsp_write_page    = rsp_ff.write_page;
   assign rsp_write_row     = rsp_ff.write_row;
   assign rsp_write_column  = rsp_ff.write_column;
   assign rsp_scroll_lines  = rsp_ff.scroll_lines;
   assign rsp_cursor_row    = rsp_ff.cursor_row;
   assign rsp_cursor_column = rsp_ff.cursor_column;

endmodule

// ===== hw/rtl/tcc_checker.sv =====
// Port-level checks for the text console cursor engine, bound to the top level.
module tcc_assertions (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_write_valid,
   input logic [7:0] rsp_write_char,
   input logic [7:0] rsp_write_row,
   input logic [7:0] rsp_write_column,
   input logic [7:0] rsp_cursor_row,
   input logic [7:0] rsp_cursor_column
);

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted request always shows a result in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no result");

   // A result without a cell write carries zero cell fields.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_valid) |->
         (rsp_write_char == 8'd0 && rsp_write_row == 8'd0 && rsp_write_column == 8'd0))
      else $error("cell fields set without a write");

   // A stalled result stays valid and holds its cursor fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_cursor_row) && $stable(rsp_cursor_column)))
      else $error("stalled result changed");

endmodule

bind text_console_cursor_engine tcc_assertions u_tcc_assertions (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_write_valid   (rsp_write_valid),
   .rsp_write_char    (rsp_write_char),
   .rsp_write_row     (rsp_write_row),
   .rsp_write_column  (rsp_write_column),
   .rsp_cursor_row    (rsp_cursor_row),
   .rsp_cursor_column (rsp_cursor_column)
);
